### design/lcs_pkg.sv
// shared types and constants for the lexicographic combination successor
// used by every stage module and the top level; no dependencies
package lcs_pkg;

  localparam int POS_W    = 7;   // width of one slot value
  localparam int SET_W    = 7;   // width of the set size register
  localparam int CHOOSE_W = 4;   // width of the choose count register
  localparam int R_W      = 5;   // clamped choose count, holds up to 16
  localparam int CEIL_W   = 9;   // signed slot ceiling n - r + k + one

  typedef enum logic [1:0] {
    CFG_SET_SIZE     = 2'd0,
    CFG_CHOOSE_COUNT = 2'd1,
    CFG_START_AT_ONE = 2'd2
  } cfg_idx_t;

  // clamped configuration as seen by the stages
  typedef struct packed {
    logic [SET_W-1:0] n;
    logic [R_W-1:0]   r;
    logic             one;
  } cfg_t;

endpackage

### design/lcs_cmp.sv
// stage 1: compares every slot against its ceiling and registers the flags
// depends on lcs_pkg
module lcs_cmp import lcs_pkg::*; #(
  parameter int MAX_CHOOSE = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  cfg_t                             cfg,
  input  logic                             in_valid,
  input  logic [MAX_CHOOSE-1:0][POS_W-1:0] in_vals,
  output logic                             valid_r,
  output logic [MAX_CHOOSE-1:0][POS_W-1:0] vals_r,
  output logic [MAX_CHOOSE-1:0]            below_r
);

  logic signed [CEIL_W-1:0] ceil [MAX_CHOOSE];
  logic [MAX_CHOOSE-1:0]    below_nxt;

  always_comb begin
    for (int k = 0; k < MAX_CHOOSE; k++) begin
      ceil[k] = $signed({2'b00, cfg.n}) - $signed({4'b0000, cfg.r})
              + $signed(CEIL_W'(k)) + $signed({8'b0, cfg.one});
      // slots at or beyond r never advance
      below_nxt[k] = (R_W'(k) < cfg.r) && ($signed({2'b00, in_vals[k]}) < ceil[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vals_r  <= in_vals;
      below_r <= below_nxt;
    end
  end

endmodule

### design/lcs_pick.sv
// stage 2: picks the rightmost slot below its ceiling and forms the refill base
// depends on lcs_pkg
module lcs_pick import lcs_pkg::*; #(
  parameter int MAX_CHOOSE = 8,
  parameter int KW         = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [MAX_CHOOSE-1:0][POS_W-1:0] in_vals,
  input  logic [MAX_CHOOSE-1:0]            in_below,
  output logic                             valid_r,
  output logic [MAX_CHOOSE-1:0][POS_W-1:0] vals_r,
  output logic                             found_r,
  output logic [KW-1:0]                    pick_r,
  output logic [POS_W-1:0]                 base_r
);

  logic [KW-1:0]    pick_nxt;
  logic [POS_W-1:0] base_nxt;

  always_comb begin
    pick_nxt = '0;
    // later slots override, so the rightmost one wins
    for (int k = 0; k < MAX_CHOOSE; k++) begin
      if (in_below[k]) begin
        pick_nxt = KW'(k);
      end
    end
    base_nxt = in_vals[pick_nxt] + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vals_r  <= in_vals;
      found_r <= |in_below;
      pick_r  <= pick_nxt;
      base_r  <= base_nxt;
    end
  end

endmodule

### design/lcs_fill.sv
// stage 3: refills the picked slot and those right of it, registers the result
// depends on lcs_pkg
module lcs_fill import lcs_pkg::*; #(
  parameter int MAX_CHOOSE = 8,
  parameter int KW         = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic [R_W-1:0]                   r,
  input  logic                             in_valid,
  input  logic [MAX_CHOOSE-1:0][POS_W-1:0] in_vals,
  input  logic                             in_found,
  input  logic [KW-1:0]                    in_pick,
  input  logic [POS_W-1:0]                 in_base,
  output logic                             valid_r,
  output logic [MAX_CHOOSE-1:0][POS_W-1:0] next_r,
  output logic                             wrapped_r
);

  logic [MAX_CHOOSE-1:0][POS_W-1:0] next_nxt;

  always_comb begin
    for (int s = 0; s < MAX_CHOOSE; s++) begin
      if (in_found && (KW'(s) >= in_pick) && (R_W'(s) < r)) begin
        next_nxt[s] = in_base + POS_W'(s) - POS_W'(in_pick);
      end else begin
        next_nxt[s] = in_vals[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      next_r    <= next_nxt;
      wrapped_r <= ~in_found;
    end
  end

endmodule

### design/lex_combination_successor.sv
// Lexicographic combination successor. Each input item carries MAX_CHOOSE
// 7-bit slots of an ascending combination; the result item carries the next
// combination in lexicographic order and a wrap flag in out_tuser that is set,
// with the slots passed through, when the input was the last combination.
// The stages are compare, pick and refill, each ending in a register, and one
// item is taken each cycle unless stalled. All stages advance together whenever
// the output register is empty or being taken, so out_tready low stalls the
// whole pipeline. Configuration is written through cfg_valid/cfg_index/cfg_data
// and must only change while no item is in flight.
// depends on lcs_pkg, lcs_cmp, lcs_pick and lcs_fill
module lex_combination_successor import lcs_pkg::*; #(
  parameter int MAX_CHOOSE = 8,
  parameter int MAX_SET    = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [SET_W-1:0]      cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pos_0 .. pos_(MAX_CHOOSE-1), 7 bits each from bit 0 up, zero padded
  input  logic [((MAX_CHOOSE*POS_W+7)/8)*8-1:0] in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // next_0 .. next_(MAX_CHOOSE-1), 7 bits each from bit 0 up, zero padded
  output logic [((MAX_CHOOSE*POS_W+7)/8)*8-1:0] out_tdata,
  // wrapped
  output logic                  out_tuser
);

  localparam int DATA_W = ((MAX_CHOOSE * POS_W + 7) / 8) * 8;
  localparam int SLOT_W = MAX_CHOOSE * POS_W;
  localparam int KW     = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;

  logic [SET_W-1:0]    set_size_r;
  logic [CHOOSE_W-1:0] choose_count_r;
  logic                start_at_one_r;
  cfg_t                cfg;
  logic                advance;

  logic                             s1_valid, s2_valid, s3_valid;
  logic [MAX_CHOOSE-1:0][POS_W-1:0] s1_vals, s2_vals, s3_next;
  logic [MAX_CHOOSE-1:0]            s1_below;
  logic                             s2_found;
  logic [KW-1:0]                    s2_pick;
  logic [POS_W-1:0]                 s2_base;
  logic                             s3_wrapped;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r     <= 7'd64;
      choose_count_r <= 4'd8;
      start_at_one_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SET_SIZE:     set_size_r     <= cfg_data;
        CFG_CHOOSE_COUNT: choose_count_r <= cfg_data[CHOOSE_W-1:0];
        CFG_START_AT_ONE: start_at_one_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.n   = (int'(set_size_r) > MAX_SET) ? SET_W'(MAX_SET) : set_size_r;
    cfg.r   = (int'(choose_count_r) > MAX_CHOOSE) ? R_W'(MAX_CHOOSE)
                                                  : R_W'(choose_count_r);
    cfg.one = start_at_one_r;
  end

  assign advance   = !s3_valid || out_tready;
  assign in_tready = advance;

  lcs_cmp #(.MAX_CHOOSE(MAX_CHOOSE)) u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_vals  (in_tdata[SLOT_W-1:0]),
    .valid_r  (s1_valid),
    .vals_r   (s1_vals),
    .below_r  (s1_below)
  );

  lcs_pick #(.MAX_CHOOSE(MAX_CHOOSE), .KW(KW)) u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .in_valid (s1_valid),
    .in_vals  (s1_vals),
    .in_below (s1_below),
    .valid_r  (s2_valid),
    .vals_r   (s2_vals),
    .found_r  (s2_found),
    .pick_r   (s2_pick),
    .base_r   (s2_base)
  );

  lcs_fill #(.MAX_CHOOSE(MAX_CHOOSE), .KW(KW)) u_fill (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .r         (cfg.r),
    .in_valid  (s2_valid),
    .in_vals   (s2_vals),
    .in_found  (s2_found),
    .in_pick   (s2_pick),
    .in_base   (s2_base),
    .valid_r   (s3_valid),
    .next_r    (s3_next),
    .wrapped_r (s3_wrapped)
  );

  assign out_tvalid = s3_valid;
  assign out_tdata  = DATA_W'(s3_next);
  assign out_tuser  = s3_wrapped;

  // an accepted item always lands in the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_valid)
    else $error("accepted item did not enter stage 1");

  // a stalled pipeline keeps its items in flight
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_vals)))
    else $error("stage 1 item lost during stall");

  // the picked slot always lies inside the combination
  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid && s2_found) |-> (R_W'(s2_pick) < cfg.r))
    else $error("picked slot beyond choose count");

  // a picked slot was below its ceiling, so the result is not a wrap
  a_wrap_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s2_valid) |=> (s3_wrapped == !$past(s2_found)))
    else $error("wrap flag does not match pick result");

endmodule
